FILE: rtl/sorted_record_table_core_assert.svh
// ---------------------------------------------------------------------------
// Sorted record table assertion macros
// Clocked property wrappers, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_CORE_ASSERT_SVH
`define SORTED_RECORD_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SRT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srt: same-cycle check failed");
`define SRT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srt: next-cycle check failed");
`else
`define SRT_ASSERT_IMP(label, ante, cons)
`define SRT_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: rtl/srt_pkg.sv
// ---------------------------------------------------------------------------
// Sorted record table package
// Field widths, record type, operation codes and grade arithmetic.
// ---------------------------------------------------------------------------
package srt_pkg;

	localparam int ID_W            = 16;
	localparam int GRADE_W         = 7;
	localparam int SUM_W           = 9;
	localparam int TABLE_DEPTH_DEF = 32;

	localparam logic [GRADE_W-1:0] GRADE_MAX    = 7'd100;
	localparam logic [GRADE_W-1:0] THRESH_RESET = 7'd50;

	// floor(s / 3) == (s * 683) >> 11 for s < 384
	localparam logic [17:0] DIV3_MUL = 18'd683;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LIST   = 1'b1
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [GRADE_W-1:0] g1;
		logic [GRADE_W-1:0] g2;
		logic [GRADE_W-1:0] g3;
		logic [GRADE_W-1:0] avg;
		logic               pass;
	} rec_t;

	function automatic logic [GRADE_W-1:0] clamp_grade(input logic [GRADE_W-1:0] g);
		return (g > GRADE_MAX) ? GRADE_MAX : g;
	endfunction

	function automatic logic [GRADE_W-1:0] div3(input logic [SUM_W-1:0] s);
		logic [17:0] p;
		p = 18'(s) * DIV3_MUL;
		return p[17:11];
	endfunction

endpackage

FILE: rtl/srt_if.sv
// ---------------------------------------------------------------------------
// Sorted record table channel interfaces
// Request, response and threshold write channels, valid/ready handshake.
// ---------------------------------------------------------------------------
interface srt_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] record_id;
	logic [6:0]  grade_one;
	logic [6:0]  grade_two;
	logic [6:0]  grade_three;

	modport source (output valid, operation, record_id, grade_one, grade_two, grade_three,
		input ready);
	modport sink (input valid, operation, record_id, grade_one, grade_two, grade_three,
		output ready);
endinterface

interface srt_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_id;
	logic [6:0]  out_grade_one;
	logic [6:0]  out_grade_two;
	logic [6:0]  out_grade_three;
	logic [6:0]  average;
	logic        passed;
	logic        accepted;
	logic        table_empty;
	logic        last;

	modport source (output valid, out_id, out_grade_one, out_grade_two, out_grade_three,
		average, passed, accepted, table_empty, last, input ready);
	modport sink (input valid, out_id, out_grade_one, out_grade_two, out_grade_three,
		average, passed, accepted, table_empty, last, output ready);
endinterface

interface srt_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/srt_ram.sv
// ---------------------------------------------------------------------------
// Sorted record table RAM
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module srt_ram #(
	parameter int WIDTH = 45,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/srt_grade_unit.sv
// ---------------------------------------------------------------------------
// Sorted record table grade unit
// Clamps grades, forms the integer average and the pass flag, registered.
// ---------------------------------------------------------------------------
module srt_grade_unit import srt_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic [ID_W-1:0]    id,
	input  logic [GRADE_W-1:0] g1,
	input  logic [GRADE_W-1:0] g2,
	input  logic [GRADE_W-1:0] g3,
	input  logic [GRADE_W-1:0] thresh,
	output rec_t               rec_q
);

	logic [GRADE_W-1:0] c1, c2, c3, avg;
	logic [SUM_W-1:0]   sum;

	always_comb begin
		c1  = clamp_grade(g1);
		c2  = clamp_grade(g2);
		c3  = clamp_grade(g3);
		sum = SUM_W'(c1) + SUM_W'(c2) + SUM_W'(c3);
		avg = div3(sum);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q.id   <= id;
			rec_q.g1   <= c1;
			rec_q.g2   <= c2;
			rec_q.g3   <= c3;
			rec_q.avg  <= avg;
			rec_q.pass <= (avg >= thresh);
		end
	end

endmodule

FILE: rtl/srt_seq.sv
// ---------------------------------------------------------------------------
// Sorted record table sequencer
// Insertion walk with one shared average compare, list streaming, result
// register.
// ---------------------------------------------------------------------------
module srt_seq import srt_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	srt_req_if.sink              req,
	srt_rsp_if.source            rsp,
	input  rec_t                 rec,
	output logic                 rec_load,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [$bits(rec_t)-1:0] ram_wdata,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_raddr,
	input  logic [$bits(rec_t)-1:0] ram_rdata,
	output logic [CW-1:0]        cnt
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CALC  = 6'b000010,
		S_CMP   = 6'b000100,
		S_PLACE = 6'b001000,
		S_RES   = 6'b010000,
		S_LIST  = 6'b100000
	} state_t;

	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic [AW-1:0]  idx_q;
	logic           acc_q;
	logic           empty_q;
	logic           rvalid_q;
	rec_t           rrec_q;
	logic           racc_q, rempty_q, rlast_q;

	rec_t           rd;
	logic           accept, out_free, last_ent, greater;
	logic           out_load;

	assign rd        = rec_t'(ram_rdata);
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rvalid_q || rsp.ready;
	assign out_load  = out_free && ((state_q == S_RES) || (state_q == S_LIST));
	assign last_ent  = (CW'(idx_q) == cnt_q - 1'b1);
	assign greater   = (rd.avg > rec.avg);
	assign rec_load  = accept && (req.operation == OP_INSERT);
	assign cnt       = cnt_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = rec;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_re = accept && (req.operation == OP_LIST);
			end
			S_CALC: begin
				ram_re    = (cnt_q != '0) && (cnt_q != FULL);
				ram_raddr = AW'(cnt_q - 1'b1);
			end
			S_CMP: begin
				ram_we = 1'b1;
				if (greater) begin
					ram_wdata = rd;
					ram_re    = (idx_q != AW'(1));
					ram_raddr = idx_q - AW'(2);
				end
			end
			S_PLACE: begin
				ram_we = 1'b1;
			end
			S_RES: begin
			end
			S_LIST: begin
				ram_re    = out_free && !last_ent;
				ram_raddr = idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			acc_q    <= 1'b0;
			empty_q  <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rvalid_q <= 1'b1;
			end else if (rsp.ready) begin
				rvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (req.operation == OP_LIST) begin
							if (cnt_q == '0) begin
								empty_q <= 1'b1;
								acc_q   <= 1'b0;
								state_q <= S_RES;
							end else begin
								state_q <= S_LIST;
							end
						end else begin
							empty_q <= 1'b0;
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					acc_q <= (cnt_q != FULL);
					if (cnt_q == FULL) begin
						state_q <= S_RES;
					end else if (cnt_q == '0) begin
						state_q <= S_PLACE;
					end else begin
						idx_q   <= AW'(cnt_q);
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (greater) begin
						idx_q <= idx_q - 1'b1;
						if (idx_q == AW'(1)) begin
							state_q <= S_PLACE;
						end
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_RES;
					end
				end
				S_PLACE: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (out_free) begin
						idx_q <= idx_q + 1'b1;
						if (last_ent) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_free && (state_q == S_RES)) begin
			rrec_q   <= empty_q ? '0 : rec;
			racc_q   <= acc_q;
			rempty_q <= empty_q;
			rlast_q  <= 1'b1;
		end else if (out_free && (state_q == S_LIST)) begin
			rrec_q   <= rd;
			racc_q   <= 1'b0;
			rempty_q <= 1'b0;
			rlast_q  <= last_ent;
		end
	end

	assign rsp.valid           = rvalid_q;
	assign rsp.out_id          = rrec_q.id;
	assign rsp.out_grade_one   = rrec_q.g1;
	assign rsp.out_grade_two   = rrec_q.g2;
	assign rsp.out_grade_three = rrec_q.g3;
	assign rsp.average         = rrec_q.avg;
	assign rsp.passed          = rrec_q.pass;
	assign rsp.accepted        = racc_q;
	assign rsp.table_empty     = rempty_q;
	assign rsp.last            = rlast_q;

endmodule

FILE: rtl/sorted_record_table_core.sv
// ---------------------------------------------------------------------------
// Sorted record table core
// Record table kept in ascending order of average, with insert and list.
//
//   port   dir    role
//   req    sink   insert or list request transactions
//   rsp    source result transactions, last marks the final one per request
//   cfg    sink   pass threshold write transactions, always ready
//
// Insert: walks past the n entries with a greater average, one
// compare-and-move per cycle through the single RAM read port.
// List: reads entry 0 on accept, then one result per cycle while rsp is ready.
// Reset clears the entry count and sets the threshold to 50; no clearing pass.
// A stalled result holds in the output register; req stays not ready until
// the request's last result is loaded.
// ---------------------------------------------------------------------------
`include "sorted_record_table_core_assert.svh"

module sorted_record_table_core import srt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	srt_req_if.sink   req,
	srt_rsp_if.source rsp,
	srt_cfg_if.sink   cfg
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [GRADE_W-1:0]      thresh_q;
	rec_t                    rec;
	logic                    rec_load;
	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [$bits(rec_t)-1:0] ram_wdata, ram_rdata;
	logic [CW-1:0]           cnt;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			thresh_q <= cfg.data;
		end
	end

	srt_grade_unit u_grade (
		.clk    (clk),
		.load   (rec_load),
		.id     (req.record_id),
		.g1     (req.grade_one),
		.g2     (req.grade_two),
		.g3     (req.grade_three),
		.thresh (thresh_q),
		.rec_q  (rec)
	);

	srt_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srt_seq #(
		.DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rec       (rec),
		.rec_load  (rec_load),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.cnt       (cnt)
	);

	`SRT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= CW'(TABLE_DEPTH))
	`SRT_ASSERT_IMP(a_cnt_step, 1'b1, (cnt == $past(cnt)) || (cnt == $past(cnt) + 1'b1))
	`SRT_ASSERT_NXT(a_busy_after_req, req.valid && req.ready, !req.ready)
	`SRT_ASSERT_IMP(a_empty_last, rsp.valid && rsp.table_empty, rsp.last && !rsp.accepted)

endmodule
